// ===== hw/rtl/mm_pwm_pkg.sv =====
package mm_pwm_pkg;

    // Motor modes, as reported on the mode output.
    typedef enum logic [2:0] {
        MODE_NOINIT = 3'd0,
        MODE_OFF    = 3'd1,
        MODE_ON     = 3'd2,
        MODE_ACCEL  = 3'd3,
        MODE_TRY    = 3'd4,
        MODE_ERROR  = 3'd5,
        MODE_REG    = 3'd6
    } t_mode;

    // Command codes. Codes above ACT_SET_PCT are rejected.
    typedef enum logic [3:0] {
        ACT_PROCESS = 4'd0,
        ACT_START   = 4'd1,
        ACT_STOP    = 4'd2,
        ACT_ERROR   = 4'd3,
        ACT_TRY     = 4'd4,
        ACT_NORMAL  = 4'd5,
        ACT_REGUL   = 4'd6,
        ACT_INIT    = 4'd7,
        ACT_DEINIT  = 4'd8,
        ACT_SET_PCT = 4'd9
    } t_action;

    // Configuration register indexes.
    typedef enum logic [7:0] {
        CFG_CAL_MIN = 8'd0,
        CFG_CAL_MAX = 8'd1,
        CFG_DEF_MIN = 8'd2,
        CFG_DEF_MAX = 8'd3
    } t_cfg_index;

    localparam int PCT_W = 7;                    // percentages 0..100
    localparam int PROD_W = 15;                  // 8-bit span times 7-bit percent
    localparam int RECIP_W = 13;
    localparam int RECIP_SHIFT = 19;
    // floor(x / 100) == (x * 5243) >> 19 for every x below 2**15.
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

    localparam logic [7:0] PCT_FULL = 8'd100;
    localparam logic [7:0] TRY_LOW_LIMIT = 8'd50;
    localparam logic [7:0] TRY_HIGH_LIMIT = 8'd70;
    localparam logic [7:0] TRY_LOW_BOOST = 8'd20;
    localparam logic [7:0] TRY_HIGH_BOOST = 8'd15;

    localparam logic [7:0] CAL_MIN_RST = 8'd0;
    localparam logic [7:0] CAL_MAX_RST = 8'd255;

endpackage

// ===== hw/rtl/motor_mode_pwm_controller.sv =====
// Motor mode controller with a calibrated PWM level.
//
// Commands enter on the input channel (i_in_valid / o_in_stall with i_action
// and i_value) and every command produces exactly one result on the output
// channel (o_out_valid / i_out_stall with o_pwm_out, o_accepted, o_mode and
// o_running). A transfer happens on a rising edge where valid is high and
// stall is low. Calibration is written through the configuration channel
// (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data); o_cfg_ready is always
// high, and writes are expected only while no command is in flight.
//
// A command is captured in the input register, then executed against the mode and
// PWM state, and its result lands in the output register. Throughput is one
// command per cycle while the receiver does not stall, and the following command
// always sees the updated mode. The percentage products are formed ahead of the
// input register so the execute cycle holds only the divide-by-100 reciprocal
// multiply and an add.
//
// Synchronous reset puts the motor in the not-initialized mode with PWM zero
// and restores the default calibration. When the receiver stalls, the result
// holds and one more command can still be captured before o_in_stall rises.
module motor_mode_pwm_controller (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [3:0] i_action,
    input  logic [7:0] i_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_pwm_out,
    output logic       o_accepted,
    output logic [2:0] o_mode,
    output logic       o_running,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import mm_pwm_pkg::*;

    // Calibration registers.
    logic [7:0] r_cal_min, r_cal_max, r_def_min, r_def_max;

    // Motor state.
    t_mode      r_mode, n_mode;
    logic [7:0] r_pwm, n_pwm;

    // Input register, holding the command and its precomputed products.
    logic              r_in_vld;
    logic [3:0]        r_action;
    logic [7:0]        r_value;
    logic [7:0]        r_lo;
    logic              r_inv;
    logic [PROD_W-1:0] r_prod_plain;
    logic [PROD_W-1:0] r_prod_try;

    // Output register.
    logic       r_out_vld;
    logic [7:0] r_out_pwm;
    logic       r_out_acc;
    t_mode      r_out_mode;
    logic       r_out_run;

    logic in_take, exec;
    logic n_acc;

    // Front-end mapping terms, from the raw command and the calibration.
    logic             cal_inv, def_inv;
    logic [7:0]       lo_sel, hi_sel, span;
    logic [7:0]       pct_try_raw;
    logic [PCT_W-1:0] pct_plain, pct_try;

    // Execute-cycle mapping terms.
    logic                      use_try, pct_zero, running;
    logic [PROD_W-1:0]         prod_sel;
    logic [PROD_W+RECIP_W-1:0] quot_full;
    logic [7:0]                quot, map_val;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_min <= CAL_MIN_RST;
            r_cal_max <= CAL_MAX_RST;
            r_def_min <= CAL_MIN_RST;
            r_def_max <= CAL_MAX_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CAL_MIN: r_cal_min <= i_cfg_data;
                CFG_CAL_MAX: r_cal_max <= i_cfg_data;
                CFG_DEF_MIN: r_def_min <= i_cfg_data;
                CFG_DEF_MAX: r_def_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: the execute step fires when the output register is free or
    // being drained in the same cycle.
    assign exec       = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !exec;
    assign in_take    = i_in_valid && !o_in_stall;

    // Pick the calibration range. An inverted calibration falls back to the
    // defaults; inverted defaults make the mapping return the default minimum.
    always_comb begin
        cal_inv = r_cal_min > r_cal_max;
        def_inv = r_def_min > r_def_max;
        lo_sel  = cal_inv ? r_def_min : r_cal_min;
        hi_sel  = cal_inv ? r_def_max : r_cal_max;
        span    = hi_sel - lo_sel;

        pct_plain = (i_value > PCT_FULL) ? PCT_FULL[PCT_W-1:0] : i_value[PCT_W-1:0];
        if (i_value <= TRY_LOW_LIMIT) begin
            pct_try_raw = i_value + TRY_LOW_BOOST;
        end else if (i_value <= TRY_HIGH_LIMIT) begin
            pct_try_raw = i_value + TRY_HIGH_BOOST;
        end else begin
            pct_try_raw = i_value;
        end
        pct_try = (pct_try_raw > PCT_FULL) ? PCT_FULL[PCT_W-1:0] : pct_try_raw[PCT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (exec) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action     <= i_action;
            r_value      <= i_value;
            r_lo         <= lo_sel;
            r_inv        <= cal_inv && def_inv;
            r_prod_plain <= PROD_W'(span) * PROD_W'(pct_plain);
            r_prod_try   <= PROD_W'(span) * PROD_W'(pct_try);
        end
    end

    // Finish the mapping: the boosted percentage is used only when a process
    // command meets the try mode, and a boosted percentage is never zero.
    always_comb begin
        use_try   = (r_action == ACT_PROCESS) && (r_mode == MODE_TRY);
        pct_zero  = !use_try && (r_value == 8'd0);
        prod_sel  = use_try ? r_prod_try : r_prod_plain;
        quot_full = (PROD_W + RECIP_W)'(prod_sel) * (PROD_W + RECIP_W)'(RECIP_100);
        quot      = quot_full[RECIP_SHIFT +: 8];
        if (pct_zero) begin
            map_val = 8'd0;
        end else if (r_inv) begin
            map_val = r_lo;
        end else begin
            map_val = r_lo + quot;
        end
    end

    // Mode state machine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NOINIT;
            r_pwm  <= 8'd0;
        end else if (exec) begin
            r_mode <= n_mode;
            r_pwm  <= n_pwm;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_pwm   = r_pwm;
        n_acc   = 1'b1;
        running = (r_mode == MODE_ON) || (r_mode == MODE_ACCEL) || (r_mode == MODE_TRY);
        unique case (r_action)
            ACT_PROCESS: begin
                unique case (r_mode) inside
                    MODE_ON, MODE_REG, MODE_TRY: n_pwm = map_val;
                    MODE_OFF: n_pwm = 8'd0;
                    MODE_ACCEL: n_mode = MODE_ON;
                    default: ;
                endcase
            end
            ACT_START: begin
                if (r_mode == MODE_OFF) begin
                    n_mode = MODE_ACCEL;
                end else begin
                    n_acc = 1'b0;
                end
            end
            ACT_STOP: begin
                if (running) begin
                    n_mode = MODE_OFF;
                end else begin
                    n_acc = 1'b0;
                end
            end
            ACT_ERROR: n_mode = MODE_ERROR;
            ACT_TRY: begin
                if (running) begin
                    n_mode = MODE_TRY;
                end else begin
                    n_acc = 1'b0;
                end
            end
            ACT_NORMAL: begin
                if (running) begin
                    n_mode = MODE_ON;
                end else begin
                    n_acc = 1'b0;
                end
            end
            ACT_REGUL: begin
                n_mode = MODE_REG;
                n_pwm  = r_value;
            end
            ACT_INIT: n_mode = MODE_OFF;
            ACT_DEINIT: n_mode = MODE_NOINIT;
            ACT_SET_PCT: n_pwm = map_val;
            default: n_acc = 1'b0;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (exec) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out_pwm  <= n_pwm;
            r_out_acc  <= n_acc;
            r_out_mode <= n_mode;
            r_out_run  <= (n_mode == MODE_ON) || (n_mode == MODE_ACCEL) ||
                          (n_mode == MODE_TRY);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_pwm_out   = r_out_pwm;
    assign o_accepted  = r_out_acc;
    assign o_mode      = r_out_mode;
    assign o_running   = r_out_run;

    // The running flag of a result matches its mode.
    a_running_matches_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_running == ((o_mode == MODE_ON) || (o_mode == MODE_ACCEL) ||
                                       (o_mode == MODE_TRY))))
        else $error("running flag disagrees with mode");

    // A rejected command leaves the motor mode untouched.
    a_reject_keeps_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(exec) && !r_out_acc) |-> (r_mode == $past(r_mode)))
        else $error("rejected command changed the mode");

    // Input backpressure only comes from a held result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && r_in_vld))
        else $error("input stalled without a held result");

    // The published mode is the mode the next command executes against.
    a_mode_published: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(exec)) |-> (r_out_mode == r_mode))
        else $error("result mode differs from state");

endmodule

// ===== tb/motor_mode_pwm_controller_tb.sv =====
`timescale 1ns / 1ps

module motor_mode_pwm_controller_tb;

    import mm_pwm_pkg::*;

    // Highest code the 4-bit action field can carry. Codes past ACT_SET_PCT are
    // not commands and must be rejected without touching the state.
    localparam logic [3:0] ACT_LAST_CODE = 4'hF;

    localparam int PHASE_COUNT = 8;
    localparam int ITEMS_PER_PHASE = 228;
    localparam int HOLD_CYCLES = 60;      // long receiver hold-off
    localparam int DRAIN_CYCLES = 8;      // settle time after the last result
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [3:0] action;
        logic [7:0] value;
    } t_motor_cmd;

    typedef struct packed {
        logic [7:0] pwm;
        logic       accepted;
        t_mode      mode;
        logic       running;
    } t_motor_result;

    // Clock, reset, and every block input start at a known value.
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [3:0] i_action = '0;
    logic [7:0] i_value = '0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_pwm_out;
    logic       o_accepted;
    logic [2:0] o_mode;
    logic       o_running;
    logic       o_cfg_ready;

    motor_mode_pwm_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pwm_out   (o_pwm_out),
        .o_accepted  (o_accepted),
        .o_mode      (o_mode),
        .o_running   (o_running),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Commands waiting to be offered, and the results the block owes us, oldest
    // first. Every transferred command owes exactly one result.
    t_motor_cmd    cmd_queue[$];
    t_motor_result result_queue[$];

    // Shadow copy of the block's state and calibration, advanced once per
    // accepted command and once per accepted register write.
    t_mode      mode_model;
    logic [7:0] pwm_model;
    logic [7:0] cal_min_model;
    logic [7:0] cal_max_model;
    logic [7:0] def_min_model;
    logic [7:0] def_max_model;

    int unsigned fail_count = 0;
    int unsigned issued = 0;

    // When set, the matching side runs without any idle cycles. Bar the first set of
    // quiet_send, they change on the falling edge, so clocked blocks see them settled.
    bit quiet_send = 1'b0;
    bit quiet_recv = 1'b0;

    // A one-cycle pulse on hold_trigger starts the long receiver hold-off,
    // which is counted down in its own process.
    logic hold_trigger = 1'b0;
    int unsigned hold_left = 0;

    // Percentages around the try-mode boost limits and the clamp at 100.
    logic [7:0] pct_corners[12] = '{8'd0, 8'd1, 8'd49, 8'd50, 8'd51, 8'd69,
                                    8'd70, 8'd71, 8'd99, 8'd100, 8'd101, 8'd255};

    function automatic bit motor_spinning(t_mode m);
        return m == MODE_ON || m == MODE_ACCEL || m == MODE_TRY;
    endfunction

    // Map a percentage onto the calibrated PWM range. A percentage of zero is
    // always zero. Inverted calibration falls back on the defaults, and when
    // those are inverted too the default minimum is put out as it is.
    function automatic logic [7:0] pct_to_pwm(int unsigned pct);
        int unsigned lo;
        int unsigned hi;
        int unsigned level;
        if (pct > PCT_FULL) pct = PCT_FULL;
        if (pct == 0) return '0;
        lo = cal_min_model;
        hi = cal_max_model;
        if (lo > hi) begin
            lo = def_min_model;
            hi = def_max_model;
            if (lo > hi) return lo[7:0];
        end
        level = lo + (hi - lo) * pct / PCT_FULL;
        return level[7:0];
    endfunction

    // Apply one command to the shadow state and return the result it causes.
    function automatic t_motor_result run_command(logic [3:0] action, logic [7:0] value);
        t_motor_result res;
        logic ok;
        int unsigned pct;
        ok = 1'b1;
        pct = value;
        case (action)
            ACT_PROCESS: begin
                case (mode_model)
                    MODE_ON, MODE_REG: pwm_model = pct_to_pwm(pct);
                    MODE_OFF: pwm_model = '0;
                    MODE_TRY: begin
                        // Try mode boosts low and middle percentages.
                        if (pct <= TRY_LOW_LIMIT) pct += TRY_LOW_BOOST;
                        else if (pct <= TRY_HIGH_LIMIT) pct += TRY_HIGH_BOOST;
                        pwm_model = pct_to_pwm(pct);
                    end
                    MODE_ACCEL: mode_model = MODE_ON;
                    default: ;
                endcase
            end
            ACT_START: begin
                if (mode_model == MODE_OFF) mode_model = MODE_ACCEL;
                else ok = 1'b0;
            end
            ACT_STOP: begin
                if (motor_spinning(mode_model)) mode_model = MODE_OFF;
                else ok = 1'b0;
            end
            ACT_ERROR: mode_model = MODE_ERROR;
            ACT_TRY: begin
                if (motor_spinning(mode_model)) mode_model = MODE_TRY;
                else ok = 1'b0;
            end
            ACT_NORMAL: begin
                if (motor_spinning(mode_model)) mode_model = MODE_ON;
                else ok = 1'b0;
            end
            ACT_REGUL: begin
                mode_model = MODE_REG;
                pwm_model = value;
            end
            ACT_INIT: mode_model = MODE_OFF;
            ACT_DEINIT: mode_model = MODE_NOINIT;
            ACT_SET_PCT: pwm_model = pct_to_pwm(pct);
            default: ok = 1'b0;
        endcase
        res.pwm = pwm_model;
        res.accepted = ok;
        res.mode = mode_model;
        res.running = motor_spinning(mode_model);
        return res;
    endfunction

    function automatic void queue_cmd(logic [3:0] action, logic [7:0] value);
        t_motor_cmd cmd;
        cmd.action = action;
        cmd.value = value;
        cmd_queue.push_back(cmd);
        issued++;
    endfunction

    // Percentages are mostly in range, with the boost limits and the clamp
    // visited often and the full 8-bit span still covered.
    function automatic logic [7:0] pick_value();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 255));
            1: return 8'($urandom_range(0, 110));
            2: return pct_corners[$urandom_range(0, 11)];
            default: return 8'($urandom_range(0, 100));
        endcase
    endfunction

    // One motor session: bring the motor up, run it through a mix of commands,
    // then end it in one of several ways or leave it as it is. A little noise follows.
    function automatic void add_session();
        int unsigned steps;
        int unsigned noise;
        queue_cmd(ACT_INIT, pick_value());
        if ($urandom_range(0, 3) == 0) queue_cmd(ACT_PROCESS, pick_value());
        queue_cmd(ACT_START, pick_value());
        if ($urandom_range(0, 4) != 0) queue_cmd(ACT_PROCESS, pick_value());
        steps = $urandom_range(2, 10);
        repeat (steps) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: queue_cmd(ACT_PROCESS, pick_value());
                5: queue_cmd(ACT_SET_PCT, pick_value());
                6: queue_cmd(ACT_TRY, pick_value());
                7: queue_cmd(ACT_NORMAL, pick_value());
                8: queue_cmd(ACT_START, pick_value());
                default: queue_cmd(ACT_STOP, pick_value());
            endcase
        end
        case ($urandom_range(0, 4))
            0: queue_cmd(ACT_STOP, pick_value());
            1: queue_cmd(ACT_ERROR, pick_value());
            2: begin
                queue_cmd(ACT_REGUL, 8'($urandom_range(0, 255)));
                queue_cmd(ACT_PROCESS, pick_value());
            end
            3: queue_cmd(ACT_DEINIT, pick_value());
            default: ;
        endcase
        noise = $urandom_range(0, 2);
        repeat (noise) queue_cmd(4'($urandom_range(0, ACT_LAST_CODE)), 8'($urandom_range(0, 255)));
    endfunction

    // Block until nothing is queued, nothing is offered and every result is
    // back. Checked on the falling edge, where all clocked updates are done.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (cmd_queue.size() != 0 || i_in_valid || result_queue.size() != 0);
    endtask

    // Write all four calibration registers back to back. Valid stays high for
    // the whole burst and drops once after the last transfer.
    task automatic write_calibration(logic [7:0] cmin, logic [7:0] cmax,
                                     logic [7:0] dmin, logic [7:0] dmax);
        t_cfg_index regs[4];
        logic [7:0] vals[4];
        regs = '{CFG_CAL_MIN, CFG_CAL_MAX, CFG_DEF_MIN, CFG_DEF_MAX};
        vals = '{cmin, cmax, dmin, dmax};
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        foreach (regs[k]) begin
            i_cfg_index <= regs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (regs[k])
                CFG_CAL_MIN: cal_min_model = vals[k];
                CFG_CAL_MAX: cal_max_model = vals[k];
                CFG_DEF_MIN: def_min_model = vals[k];
                default:     def_max_model = vals[k];
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Command driver. A command stays on the port until it transfers; the
    // expected result is computed from the payload at the transfer edge. Between
    // commands the driver idles for a random number of cycles unless quiet.
    int unsigned send_gap = 0;

    always @(posedge i_clk) begin
        t_motor_cmd next_cmd;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) result_queue.push_back(run_command(i_action, i_value));
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (cmd_queue.size() != 0) begin
                    next_cmd = cmd_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_action <= next_cmd.action;
                    i_value <= next_cmd.value;
                    send_gap = quiet_send ? 0 : $urandom_range(0, 9);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off counter, restarted by a pulse on hold_trigger.
    always @(posedge i_clk) begin
        if (hold_trigger) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor. Each transferred result is checked field by field against
    // the oldest expectation. After each transfer the receiver picks how long to
    // stall before taking the next one; the long hold-off overrides that.
    int unsigned recv_wait = 0;

    always @(posedge i_clk) begin
        t_motor_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_queue.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: pwm=%0d acc=%0b mode=%0d run=%0b",
                             $realtime, o_pwm_out, o_accepted, o_mode, o_running);
            end else begin
                want = result_queue.pop_front();
                if (o_pwm_out !== want.pwm || o_accepted !== want.accepted ||
                    o_mode !== want.mode || o_running !== want.running) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: mismatch: pwm %0d/%0d acc %0b/%0b mode %0d/%0d run %0b/%0b",
                                 $realtime, want.pwm, o_pwm_out, want.accepted, o_accepted,
                                 want.mode, o_mode, want.running, o_running);
                end
            end
            recv_wait = quiet_recv ? 0 : $urandom_range(0, 9);
        end
        if (hold_left != 0 || recv_wait != 0) begin
            if (hold_left == 0) recv_wait--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Main sequence: reset, a directed walk through every command with the reset
    // calibration, then random motor sessions under a series of calibrations
    // that include equal, zero-width and inverted ranges.
    initial begin
        int unsigned target;
        mode_model = MODE_NOINIT;
        pwm_model = '0;
        cal_min_model = CAL_MIN_RST;
        cal_max_model = CAL_MAX_RST;
        def_min_model = CAL_MIN_RST;
        def_max_model = CAL_MAX_RST;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk. Nothing may happen before init, off clears the PWM,
        // acceleration ends on the next process, try mode boosts on both sides
        // of its limits, percentages above 100 clamp, and unused codes are
        // rejected.
        quiet_send = 1'b1;
        queue_cmd(ACT_PROCESS, 8'd0);
        queue_cmd(ACT_START, 8'd255);
        queue_cmd(ACT_INIT, 8'd0);
        queue_cmd(ACT_PROCESS, 8'd50);
        queue_cmd(ACT_STOP, 8'd0);
        queue_cmd(ACT_START, 8'd0);
        queue_cmd(ACT_PROCESS, 8'd0);
        queue_cmd(ACT_SET_PCT, 8'd255);
        queue_cmd(ACT_PROCESS, 8'd100);
        queue_cmd(ACT_PROCESS, 8'd1);
        queue_cmd(ACT_TRY, 8'd0);
        queue_cmd(ACT_PROCESS, 8'd0);
        queue_cmd(ACT_PROCESS, 8'd50);
        queue_cmd(ACT_PROCESS, 8'd51);
        queue_cmd(ACT_PROCESS, 8'd70);
        queue_cmd(ACT_PROCESS, 8'd71);
        queue_cmd(ACT_PROCESS, 8'd255);
        queue_cmd(ACT_NORMAL, 8'd0);
        queue_cmd(ACT_STOP, 8'd0);
        queue_cmd(ACT_REGUL, 8'd255);
        queue_cmd(ACT_PROCESS, 8'd37);
        queue_cmd(ACT_ERROR, 8'd0);
        queue_cmd(ACT_PROCESS, 8'd90);
        queue_cmd(ACT_LAST_CODE, 8'd0);
        queue_cmd(ACT_DEINIT, 8'd0);
        wait_idle();

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            quiet_send = (ph == 1) || ($urandom_range(0, 3) == 0);
            quiet_recv = (ph != 1) && ($urandom_range(0, 3) == 0);
            case (ph)
                0: write_calibration(8'd0, 8'd255, 8'd0, 8'd255);
                1: write_calibration(8'd255, 8'd255, 8'd0, 8'd255);
                2: write_calibration(8'd0, 8'd0, 8'd255, 8'd255);
                3: write_calibration(8'd200, 8'd50, 8'd10, 8'd240);
                4: write_calibration(8'd200, 8'd50, 8'd250, 8'd5);
                5: write_calibration(8'd255, 8'd0, 8'd255, 8'd0);
                6: write_calibration(8'($urandom_range(0, 120)), 8'($urandom_range(130, 255)),
                                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: write_calibration(8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)));
            endcase

            target = issued + ITEMS_PER_PHASE / 2;
            while (issued < target) add_session();

            // With the sender running flat out, the long hold-off backs the
            // block up until it stalls its input.
            if (ph == 1) begin
                @(posedge i_clk);
                hold_trigger <= 1'b1;
                @(posedge i_clk);
                hold_trigger <= 1'b0;
            end

            // In even phases the sender pauses mid-phase until every result has come back.
            if (ph % 2 == 0) wait_idle();

            target = issued + ITEMS_PER_PHASE / 2;
            while (issued < target) add_session();
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (result_queue.size() != 0) fail_count++;

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Run-time limit, far above the slowest legal run.
    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
